[rtl/tpss_pkg.sv]
// Shared types, constants and helpers for the thermal print step sequencer.
package tpss_pkg;

  // Print line buffer depth, its derived count width and the field widths
  localparam int BUFFER_LINES = 64;
  localparam int LINES_W      = $clog2(BUFFER_LINES + 1);
  localparam int LINE_IDX_W   = 6;
  localparam int STEP_W       = 16;
  localparam int WIDTH_US_W   = 16;
  localparam int TICKS_W      = 14;

  // Forward steps forced while loading paper
  localparam logic signed [STEP_W-1:0] LOAD_STEPS = 16'sd1000;

  // Divide by five: multiply by ceil(2^18 / 5) and shift, exact for 16-bit inputs
  localparam int DIV5_RECIP = 52429;
  localparam int DIV5_SHIFT = 18;

  // Reset value of the strobe width register
  localparam logic [WIDTH_US_W-1:0] STROBE_WIDTH_RESET = 16'd2000;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_PRINT = 2'd2,
    MODE_FEED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAPER = 2'd1,
    ST_HEAD_UP  = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_FEED  = 2'd2
  } kind_t;

  // Coil drive: enable plus the two phase polarities
  typedef struct packed {
    logic b_pos;
    logic a_pos;
    logic en;
  } coil_t;

  // One result transaction
  typedef struct packed {
    mode_t                 mode;
    logic [LINE_IDX_W-1:0] index;
    logic                  send;
    logic [TICKS_W-1:0]    ticks;
    logic                  strobe;
    coil_t                 coil;
    status_t               status;
  } res_t;

  // Gray sequence 0,1,3,2 over the phase index
  function automatic logic [1:0] gray_code(input logic [1:0] idx);
    logic [1:0] g;
    case (idx)
      2'd0:    g = 2'd0;
      2'd1:    g = 2'd1;
      2'd2:    g = 2'd3;
      default: g = 2'd2;
    endcase
    return g;
  endfunction

endpackage

[rtl/thermal_print_step_sequencer.sv]
// Thermal print step sequencer: streaming top level with result register.
//
// Usage:
//   Input stream s_axis: one transaction per stepper tick, print command or feed
//   command. s_axis_tuser carries the kind, s_axis_tdata the sensor bits and
//   the signed line or step count.
//   Output stream m_axis: exactly one result per input transaction, in order:
//   status, coil drive, strobe, strobe length, line fetch request, mode.
//   cfg_wr_en / cfg_wr_data write the strobe width in microseconds; write it
//   only while no transaction is in flight.
// Result timing and throughput:
//   The result is registered and appears on m_axis in the cycle after the input
//   is accepted. The state update is one short pass between the state registers
//   and the result register, so one transaction is taken every cycle without a stall.
// Reset (rst, synchronous): mode idle, stepper counts and coils cleared, no
//   result pending, strobe width back to 2000 us.
// Stall: while m_axis_tready is low and a result is held, s_axis_tready drops;
//   it rises in the same cycle the held result is taken.
module thermal_print_step_sequencer
  import tpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_US_W-1:0] cfg_wr_data,    // strobe_width_us
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // paper_present, head_down, line_count[15:0]
  input  logic [1:0]            s_axis_tuser,   // kind[1:0]
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata    // status[1:0], coil_enable, coil_a_positive,
                                                // coil_b_positive, strobe_res,
                                                // strobe_ticks[13:0], send_line,
                                                // line_index[5:0], mode[1:0]
);

  logic [WIDTH_US_W-1:0] strobe_width_us;
  logic [TICKS_W-1:0]    strobe_ticks;
  logic                  take;
  res_t                  res_next;
  res_t                  res;

  // Strobe width register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_width_us <= STROBE_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      strobe_width_us <= cfg_wr_data;
    end
  end

  tpss_div5 u_div5 (
    .width_us (strobe_width_us),
    .ticks    (strobe_ticks)
  );

  // Accept when the result register is free or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  tpss_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .kind          (s_axis_tuser),
    .paper_present (s_axis_tdata[0]),
    .head_down     (s_axis_tdata[1]),
    .line_count    ($signed(s_axis_tdata[17:2])),
    .strobe_ticks  (strobe_ticks),
    .res           (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

  assign m_axis_tdata = {3'b000, res.mode, res.index, res.send, res.ticks, res.strobe,
                         res.coil.b_pos, res.coil.a_pos, res.coil.en, res.status};

  // Coils off means both polarity bits low
  a_coil_off_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res.coil.en) |-> (!res.coil.a_pos && !res.coil.b_pos))
    else $error("polarity driven with coils off");

  // A line fetch always comes with a strobe
  a_send_strobe: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.send) |-> res.strobe)
    else $error("line fetch without strobe");

  // Rejected commands (status not OK) never strobe or fetch
  a_cmd_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.status != ST_OK) |-> (!res.strobe && !res.send))
    else $error("strobe or fetch on a command result");

  // Empty result register always accepts
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Strobe length is never zero
  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.ticks != '0))
    else $error("zero strobe length");

endmodule

[rtl/tpss_div5.sv]
// Strobe length in timer ticks: width divided by five, plus one.
module tpss_div5
  import tpss_pkg::*;
(
  input  logic [WIDTH_US_W-1:0] width_us,
  output logic [TICKS_W-1:0]    ticks
);

  logic [31:0] prod;

  // Reciprocal multiply, quotient sits in the top bits
  assign prod  = {16'b0, width_us} * 32'(DIV5_RECIP);
  assign ticks = prod[DIV5_SHIFT +: TICKS_W] + TICKS_W'(1);

endmodule

[rtl/tpss_core.sv]
// Sequencer state and the per-transaction update of stepper, mode and print logic.
module tpss_core
  import tpss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [1:0]               kind,
  input  logic                     paper_present,
  input  logic                     head_down,
  input  logic signed [STEP_W-1:0] line_count,
  input  logic [TICKS_W-1:0]       strobe_ticks,
  output res_t                     res
);

  mode_t                     mode_reg, mode_next;
  logic signed [STEP_W-1:0]  steps_pending, steps_next;
  logic [1:0]                phase_index, phase_next;
  logic                      release_armed, release_next;
  coil_t                     coil_drive, coil_next;
  logic [LINES_W-1:0]        lines_left, lines_next;
  logic [LINES_W-1:0]        next_line, next_line_next;

  status_t                   status;
  logic                      strobe, send;
  logic [LINE_IDX_W-1:0]     index;
  logic [1:0]                gray;

  // State registers, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_IDLE;
      steps_pending <= '0;
      phase_index   <= '0;
      release_armed <= 1'b0;
      coil_drive    <= '0;
      lines_left    <= '0;
      next_line     <= '0;
    end else if (take) begin
      mode_reg      <= mode_next;
      steps_pending <= steps_next;
      phase_index   <= phase_next;
      release_armed <= release_next;
      coil_drive    <= coil_next;
      lines_left    <= lines_next;
      next_line     <= next_line_next;
    end
  end

  // Next state and result for the transaction on the input
  always_comb begin
    mode_next      = mode_reg;
    steps_next     = steps_pending;
    phase_next     = phase_index;
    release_next   = release_armed;
    coil_next      = coil_drive;
    lines_next     = lines_left;
    next_line_next = next_line;
    status         = ST_OK;
    strobe         = 1'b0;
    send           = 1'b0;
    index          = '0;
    gray           = '0;

    case (kind)
      KIND_TICK: begin
        // Stepper: one step towards zero, release coils after an idle tick
        if (steps_pending != '0) begin
          release_next = 1'b0;
          if (!steps_pending[STEP_W-1]) begin
            phase_next = phase_index + 2'd1;
            steps_next = steps_pending - STEP_W'(1);
          end else begin
            phase_next = phase_index - 2'd1;
            steps_next = steps_pending + STEP_W'(1);
          end
          gray      = gray_code(phase_next);
          coil_next = '{b_pos: gray[1], a_pos: gray[0], en: 1'b1};
        end else begin
          if (release_armed) begin
            coil_next  = '0;
            phase_next = '0;
          end
          release_next = 1'b1;
        end

        // Mode rule on the stepped count
        unique case (mode_reg)
          MODE_IDLE: begin
            if (!paper_present) mode_next = MODE_LOAD;
          end
          MODE_LOAD: begin
            if (!paper_present) begin
              if (head_down == 1'b0) begin
                if (steps_next < LOAD_STEPS) steps_next = LOAD_STEPS;
              end else begin
                steps_next = '0;
              end
            end else if (steps_next == '0) begin
              mode_next = MODE_IDLE;
            end
          end
          MODE_PRINT: begin
            if (!head_down || !paper_present) begin
              mode_next = MODE_IDLE;
            end else if (steps_next == STEP_W'(1)) begin
              strobe = 1'b1;
            end else if (steps_next == '0) begin
              // Line boundary: fetch the next line and strobe
              send           = 1'b1;
              index          = LINE_IDX_W'(next_line);
              strobe         = 1'b1;
              next_line_next = next_line + LINES_W'(1);
              if (lines_left > LINES_W'(1)) begin
                lines_next = lines_left - LINES_W'(1);
                steps_next = STEP_W'(2);
              end else begin
                lines_next = '0;
                steps_next = STEP_W'(1);
                mode_next  = MODE_IDLE;
              end
            end
          end
          MODE_FEED: begin
            if (!paper_present || steps_next == '0) mode_next = MODE_IDLE;
          end
          default: ;
        endcase
      end

      KIND_PRINT, KIND_FEED: begin
        // Command checks: paper, then head, then busy
        if (!paper_present) begin
          status = ST_NO_PAPER;
        end else if (!head_down) begin
          status = ST_HEAD_UP;
        end else if (mode_reg != MODE_IDLE) begin
          status = ST_BUSY;
        end else if (kind == KIND_PRINT) begin
          if (line_count[STEP_W-1]) begin
            lines_next = '0;
          end else if (line_count > $signed(STEP_W'(BUFFER_LINES))) begin
            lines_next = LINES_W'(BUFFER_LINES);
          end else begin
            lines_next = LINES_W'(line_count);
          end
          next_line_next = '0;
          mode_next      = MODE_PRINT;
        end else begin
          steps_next = line_count;
          mode_next  = MODE_FEED;
        end
      end

      default: ;
    endcase
  end

  assign res = '{mode:   mode_next,
                 index:  index,
                 send:   send,
                 ticks:  strobe_ticks,
                 strobe: strobe,
                 coil:   coil_next,
                 status: status};

endmodule
